// File: rtl/byte_stream_packetizer_crc_core_assert.svh
// Assertion macros for the byte stream packetizer core.
// Included by byte_stream_packetizer_crc_core.sv; no other dependencies.
`ifndef BYTE_STREAM_PACKETIZER_CRC_CORE_ASSERT_SVH
`define BYTE_STREAM_PACKETIZER_CRC_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BSPC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bspc assertion failed");
// next-cycle implication
`define BSPC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bspc assertion failed");
`else
`define BSPC_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define BSPC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: rtl/bspc_pkg.sv
// Package for the byte stream packetizer: word types, sizes, codes, CRC steps.
// No dependencies.
`default_nettype none

package bspc_pkg;

  localparam int NUM_DEVICES = 4;
  localparam int MAX_PAYLOAD = 64;

  localparam int DEV_W  = 2;   // device field width
  localparam int SIZE_W = 7;   // payload_size field width
  localparam int USZ_W  = 7;   // per-device usual size width
  localparam int TMO_W  = 8;   // per-device timeout width
  localparam int PTR_W  = $clog2(MAX_PAYLOAD);
  localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
  localparam int MEM_DEPTH = NUM_DEVICES * MAX_PAYLOAD;
  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int HDR_LEN = 10;
  localparam int HIDX_W = $clog2(HDR_LEN);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [2:0] CFG_SESSION  = 3'd0;
  localparam logic [2:0] CFG_START    = 3'd1;
  localparam logic [2:0] CFG_DTYPE    = 3'd2;
  localparam logic [2:0] CFG_USUAL    = 3'd3;
  localparam logic [2:0] CFG_TIMEOUTS = 3'd4;

  localparam logic [27:0] USUAL_RST    = 28'h8102040;
  localparam logic [31:0] TIMEOUTS_RST = 32'h0A0A0A0A;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;

  typedef struct packed {
    logic             opcode;
    logic [DEV_W-1:0] device;
    logic [7:0]       data_byte;
    logic [31:0]      now_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              last;
    logic [DEV_W-1:0]  out_device;
    logic [31:0]       timestamp;
    logic [SIZE_W-1:0] payload_size;
    logic [7:0]        header_crc;
    logic [15:0]       payload_crc;
  } out_word_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
    end
    return c;
  endfunction

  // (h + f) mod MAX_PAYLOAD, with h < MAX_PAYLOAD and f <= MAX_PAYLOAD
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] h, logic [FILL_W-1:0] f);
    logic [PTR_W:0] s;
    s = (PTR_W+1)'(h) + (PTR_W+1)'(f);
    if (s >= (PTR_W+1)'(MAX_PAYLOAD)) begin
      s = s - (PTR_W+1)'(MAX_PAYLOAD);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_PAYLOAD - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(logic [DEV_W-1:0] d, logic [PTR_W-1:0] p);
    return MEM_AW'(d) * MEM_AW'(MAX_PAYLOAD) + MEM_AW'(p);
  endfunction

endpackage

`default_nettype wire

// File: rtl/byte_stream_packetizer_crc_core.sv
// Byte stream packetizer core: per-device byte FIFOs drained as CRC'd packages.
// Depends on bspc_pkg and byte_stream_packetizer_crc_core_assert.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): push words store a byte in
//    the addressed device FIFO (dropped when full); poll words check the
//    device's trigger (usual size, full FIFO, or timeout since first poll
//    that saw data) and, on a trigger, drain the FIFO as a package.
//  - Result channel (out_valid / out_stall / out_data): one word per payload
//    byte; header fields ride on every word, payload_crc on the last only.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//    writes, taken only while the core is idle; unknown indexes are ignored.
//  - Sequence: push and non-triggering poll go through accept and decode.
//    A triggering poll next runs the header CRC-8 one byte per cycle; then
//    each payload byte passes the single FIFO memory read port (ST_RD) and
//    the CRC-16 / output stage (ST_EMIT), which waits on a stalled receiver.
//  - in_stall is low only between words; the core works on one word at a time.
//  - A stalled receiver holds the output register, and the drain waits.
//  - Synchronous reset clears fills, heads, timeout tracking, state, config;
//    FIFO memory contents are not cleared and need no clearing pass.
`default_nettype none

`include "byte_stream_packetizer_crc_core_assert.svh"

module byte_stream_packetizer_crc_core
  import bspc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_word_t    in_data,
  // result words
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_word_t   out_data,
  // config writes
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a word
    ST_DECODE,  // push store or poll trigger check
    ST_HDR,     // header CRC-8, one byte per cycle
    ST_RD,      // issue FIFO memory read
    ST_EMIT     // CRC-16 update and load output register
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r [NUM_DEVICES];
  logic [FILL_W-1:0] fill_nxt [NUM_DEVICES];
  logic [PTR_W-1:0]  head_r [NUM_DEVICES];
  logic [PTR_W-1:0]  head_nxt [NUM_DEVICES];
  logic              seen_r [NUM_DEVICES];
  logic              seen_nxt [NUM_DEVICES];
  logic [31:0]       seen_time_r [NUM_DEVICES];
  logic [31:0]       seen_time_nxt [NUM_DEVICES];
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        session_r, session_nxt;
  logic [7:0]        start_r, start_nxt;
  logic [7:0]        dtype_r, dtype_nxt;
  logic [27:0]       usual_r, usual_nxt;
  logic [31:0]       tmo_r, tmo_nxt;

  // datapath
  in_word_t          item_r, item_nxt;
  out_word_t         out_data_r, out_data_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic [7:0]        hcrc_r, hcrc_nxt;
  logic [15:0]       pcrc_r, pcrc_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;

  // FIFO memory
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [MEM_AW-1:0] mem_ra;

  // decode helpers
  logic [DEV_W-1:0]   dev;
  logic               dev_ok;
  logic [FILL_W-1:0]  fill;
  logic [USZ_W-1:0]   usual_raw;
  logic [USZ_W-1:0]   usual;
  logic [TMO_W-1:0]   tmo;
  logic [31:0]        wait_ms;
  logic               trig;
  logic [HDR_LEN*8-1:0] hdr_vec;
  logic [7:0]         hdr_byte;
  logic               emit_go;
  logic               emit_last;
  logic [15:0]        pcrc_step;

  localparam int CMP_W = (FILL_W > USZ_W ? FILL_W : USZ_W) + 1;

  assign dev       = item_r.device;
  assign dev_ok    = {1'b0, dev} < (DEV_W+1)'(NUM_DEVICES);
  assign fill      = fill_r[dev];
  assign usual_raw = usual_r[int'(dev) * USZ_W +: USZ_W];
  assign usual     = (usual_raw == '0) ? USZ_W'(1) : usual_raw;
  assign tmo       = tmo_r[int'(dev) * TMO_W +: TMO_W];
  assign wait_ms   = item_r.now_ms - seen_time_r[dev];
  assign trig      = (CMP_W'(fill) >= CMP_W'(usual))
                  || (CMP_W'(fill) >= CMP_W'(MAX_PAYLOAD))
                  || (seen_r[dev] && (wait_ms >= 32'(tmo)));

  // header: start, type, device, session, time (BE), size (BE, 16 bits)
  assign hdr_vec  = {start_r, dtype_r, 8'(dev), session_r, item_r.now_ms,
                     8'h00, 8'(fill)};
  assign hdr_byte = hdr_vec[8 * (HDR_LEN - 1 - int'(hidx_r)) +: 8];

  assign emit_go   = !out_valid_r || !out_stall;
  assign emit_last = (cnt_r + FILL_W'(1)) == fill;
  assign pcrc_step = crc16_step(pcrc_r, rd_data_r);
  assign mem_ra    = mem_addr(dev, rd_ptr_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    seen_time_nxt = seen_time_r;
    out_valid_nxt = out_valid_r;
    session_nxt   = session_r;
    start_nxt     = start_r;
    dtype_nxt     = dtype_r;
    usual_nxt     = usual_r;
    tmo_nxt       = tmo_r;
    item_nxt      = item_r;
    out_data_nxt  = out_data_r;
    hidx_nxt      = hidx_r;
    hcrc_nxt      = hcrc_r;
    pcrc_nxt      = pcrc_r;
    rd_ptr_nxt    = rd_ptr_r;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_wa        = mem_addr(dev, wrap_add(head_r[dev], fill));

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SESSION:  session_nxt = cfg_data[7:0];
        CFG_START:    start_nxt   = cfg_data[7:0];
        CFG_DTYPE:    dtype_nxt   = cfg_data[7:0];
        CFG_USUAL:    usual_nxt   = cfg_data[27:0];
        CFG_TIMEOUTS: tmo_nxt     = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (dev_ok) begin
          if (item_r.opcode == OP_PUSH) begin
            if (CMP_W'(fill) < CMP_W'(MAX_PAYLOAD)) begin
              mem_we        = 1'b1;
              fill_nxt[dev] = fill + FILL_W'(1);
            end
          end else if (fill == '0 || !trig) begin
            if (fill != '0 && !seen_r[dev]) begin
              seen_nxt[dev]      = 1'b1;
              seen_time_nxt[dev] = item_r.now_ms;
            end
          end else begin
            hidx_nxt   = '0;
            hcrc_nxt   = '0;
            pcrc_nxt   = CRC16_INIT;
            rd_ptr_nxt = head_r[dev];
            cnt_nxt    = '0;
            state_nxt  = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        hcrc_nxt = crc8_step(hcrc_r, hdr_byte);
        hidx_nxt = hidx_r + HIDX_W'(1);
        if (hidx_r == HIDX_W'(HDR_LEN - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.payload_byte = rd_data_r;
          out_data_nxt.last         = emit_last;
          out_data_nxt.out_device   = dev;
          out_data_nxt.timestamp    = item_r.now_ms;
          out_data_nxt.payload_size = SIZE_W'(fill);
          out_data_nxt.header_crc   = hcrc_r;
          out_data_nxt.payload_crc  = emit_last ? pcrc_step : '0;
          pcrc_nxt                  = pcrc_step;
          rd_ptr_nxt                = ptr_inc(rd_ptr_r);
          cnt_nxt                   = cnt_r + FILL_W'(1);
          if (emit_last) begin
            head_nxt[dev]      = wrap_add(head_r[dev], fill);
            fill_nxt[dev]      = '0;
            seen_nxt[dev]      = 1'b0;
            seen_time_nxt[dev] = '0;
            state_nxt          = ST_IDLE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    hidx_r     <= hidx_nxt;
    hcrc_r     <= hcrc_nxt;
    pcrc_r     <= pcrc_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    cnt_r      <= cnt_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      session_r   <= '0;
      start_r     <= '0;
      dtype_r     <= '0;
      usual_r     <= USUAL_RST;
      tmo_r       <= TIMEOUTS_RST;
      for (int d = 0; d < NUM_DEVICES; d++) begin
        fill_r[d]      <= '0;
        head_r[d]      <= '0;
        seen_r[d]      <= 1'b0;
        seen_time_r[d] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      session_r   <= session_nxt;
      start_r     <= start_nxt;
      dtype_r     <= dtype_nxt;
      usual_r     <= usual_nxt;
      tmo_r       <= tmo_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      seen_r      <= seen_nxt;
      seen_time_r <= seen_time_nxt;
    end
  end

  // FIFO storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= item_r.data_byte;
    end
    rd_data_r <= mem[mem_ra];
  end

  // fill never runs past the FIFO size
  `BSPC_ASSERT_IMPL(a_fill_cap, clk, rst_n, state_r == ST_DECODE,
                    CMP_W'(fill) <= CMP_W'(MAX_PAYLOAD))
  // a drain only runs on a non-empty FIFO
  `BSPC_ASSERT_IMPL(a_drain_nonempty, clk, rst_n,
                    state_r == ST_HDR || state_r == ST_RD || state_r == ST_EMIT,
                    fill != '0)
  // byte count stays inside the package
  `BSPC_ASSERT_IMPL(a_cnt_range, clk, rst_n, state_r == ST_RD || state_r == ST_EMIT,
                    cnt_r < fill)
  // the last byte empties the FIFO and frees the core
  `BSPC_ASSERT_NEXT(a_last_done, clk, rst_n,
                    state_r == ST_EMIT && emit_go && emit_last,
                    state_r == ST_IDLE && fill_r[item_r.device] == '0 && out_valid_r)

endmodule

`default_nettype wire
